// ----- rtl/core/siph_pkg.sv -----
package siph_pkg;

    localparam int unsigned NSTAGE = 28;   // two stages per SipRound, 14 rounds
    localparam int unsigned ADDR_W = 4;

    // key register select: paddr[3]
    localparam logic REG_KEY0 = 1'b0;
    localparam logic REG_KEY1 = 1'b1;

    localparam logic [63:0] SIP_C0    = 64'h736f_6d65_7073_6575;
    localparam logic [63:0] SIP_C1    = 64'h646f_7261_6e64_6f6d;
    localparam logic [63:0] SIP_C2    = 64'h6c79_6765_6e65_7261;
    localparam logic [63:0] SIP_C3    = 64'h7465_6462_7974_6573;
    localparam logic [63:0] LEN_BLOCK = 64'h2000_0000_0000_0000;
    localparam logic [63:0] FINAL_XOR = 64'h0000_0000_0000_00ff;
    localparam logic [2:0]  WIDX_LEN  = 3'd4;

    typedef struct packed {
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [63:0] d;
    } t_lanes;

    typedef logic [3:0][63:0] t_msg;

    typedef struct packed {
        logic       half;    // 0: first half of round, 1: second half
        logic       xor_d;   // absorb word into d before the round
        logic       xor_c;   // finalization constant into c
        logic       xor_a;   // absorb word into a after the round
        logic [2:0] widx;    // message word, or length block
    } t_op;

    function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned r);
        rotl = (x << r) | (x >> (64 - r));
    endfunction

    function automatic t_lanes half0(input t_lanes s);
        t_lanes t;
        t   = s;
        t.a = s.a + s.b;
        t.b = rotl(s.b, 13) ^ t.a;
        t.a = rotl(t.a, 32);
        t.c = s.c + s.d;
        t.d = rotl(s.d, 16) ^ t.c;
        half0 = t;
    endfunction

    function automatic t_lanes half1(input t_lanes s);
        t_lanes t;
        t   = s;
        t.a = s.a + s.d;
        t.d = rotl(s.d, 21) ^ t.a;
        t.c = s.c + s.b;
        t.b = rotl(s.b, 17) ^ t.c;
        t.c = rotl(t.c, 32);
        half1 = t;
    endfunction

    // Schedule: word j absorbed over half rounds 4j..4j+3 (j = 4 is length),
    // finalization starts at half round 20.
    function automatic t_op stage_op(input int unsigned h);
        t_op op;
        op.half  = h[0];
        op.xor_d = (h % 4 == 0) && (h < 20);
        op.xor_c = (h == 20);
        op.xor_a = (h % 4 == 3) && (h < 20);
        op.widx  = (h < 20) ? 3'(h / 4) : WIDX_LEN;
        stage_op = op;
    endfunction

endpackage

// ----- rtl/core/siph_in_if.sv -----
interface siph_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] message_word0;
    logic [63:0] message_word1;
    logic [63:0] message_word2;
    logic [63:0] message_word3;

    modport source (output valid, message_word0, message_word1, message_word2,
                    message_word3, input ready);
    modport sink   (input valid, message_word0, message_word1, message_word2,
                    message_word3, output ready);
endinterface

// ----- rtl/core/siph_out_if.sv -----
interface siph_out_if;
    logic        valid;
    logic        ready;
    logic [47:0] short_id;

    modport source (output valid, short_id, input ready);
    modport sink   (input valid, short_id, output ready);
endinterface

// ----- rtl/core/siph_stage.sv -----
// One half SipRound plus the absorb and finalization xors scheduled for it.
module siph_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  siph_pkg::t_op     i_op,
    input  logic              i_valid,
    input  siph_pkg::t_lanes  i_lanes,
    input  siph_pkg::t_msg    i_msg,
    input  logic              i_ready,
    output logic              o_ready,
    output logic              o_valid,
    output siph_pkg::t_lanes  o_lanes,
    output siph_pkg::t_msg    o_msg
);

    logic             r_valid;
    siph_pkg::t_lanes r_lanes;
    siph_pkg::t_msg   r_msg;
    logic [63:0]      w_word;
    siph_pkg::t_lanes w_pre;
    siph_pkg::t_lanes n_lanes;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        w_word = (i_op.widx == siph_pkg::WIDX_LEN) ? siph_pkg::LEN_BLOCK
                                                    : i_msg[i_op.widx[1:0]];
        w_pre = i_lanes;
        if (i_op.xor_d) begin
            w_pre.d = w_pre.d ^ w_word;
        end
        if (i_op.xor_c) begin
            w_pre.c = w_pre.c ^ siph_pkg::FINAL_XOR;
        end
        n_lanes = i_op.half ? siph_pkg::half1(w_pre) : siph_pkg::half0(w_pre);
        if (i_op.xor_a) begin
            n_lanes.a = n_lanes.a ^ w_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_lanes <= n_lanes;
            r_msg   <= i_msg;
        end
    end

    assign o_valid = r_valid;
    assign o_lanes = r_lanes;
    assign o_msg   = r_msg;

endmodule

// ----- rtl/core/siphash24_short_id.sv -----
// SipHash-2-4 short id: 32-byte message in, 48-bit id out.
// Input transfers pass through 28 half-round stages plus the output
// register. Throughput: one transfer per cycle while the output is not stalled.
// Reset (i_rst_n low, synchronous): all stage valid bits and the output
// valid clear, both key registers return to zero.
module siphash24_short_id (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    siph_in_if.sink                        i_msg,
    siph_out_if.source                     o_id,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [siph_pkg::ADDR_W-1:0]    paddr,
    input  logic [63:0]                    pwdata,
    output logic [63:0]                    prdata,
    output logic                           pready
);

    localparam int unsigned NS = siph_pkg::NSTAGE;

    // ---------------------------------------------------------------
    // Key registers. Registers sit on 8-byte boundaries; only paddr[3]
    // is decoded, so every address hits one of the two keys.
    // ---------------------------------------------------------------
    logic [63:0] r_key0;
    logic [63:0] r_key1;
    logic        w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key0 <= '0;
            r_key1 <= '0;
        end else if (w_wr) begin
            if (paddr[3] == siph_pkg::REG_KEY0) begin
                r_key0 <= pwdata;
            end else begin
                r_key1 <= pwdata;
            end
        end
    end

    assign prdata = (paddr[3] == siph_pkg::REG_KEY0) ? r_key0 : r_key1;

    // ---------------------------------------------------------------
    // Lane initialization. The user must change keys only while idle; the
    // block does not enforce this, and keys are read straight at the pipe entry.
    // ---------------------------------------------------------------
    siph_pkg::t_lanes w_init;
    siph_pkg::t_msg   w_in_msg;

    assign w_init.a = siph_pkg::SIP_C0 ^ r_key0;
    assign w_init.b = siph_pkg::SIP_C1 ^ r_key1;
    assign w_init.c = siph_pkg::SIP_C2 ^ r_key0;
    assign w_init.d = siph_pkg::SIP_C3 ^ r_key1;

    assign w_in_msg[0] = i_msg.message_word0;
    assign w_in_msg[1] = i_msg.message_word1;
    assign w_in_msg[2] = i_msg.message_word2;
    assign w_in_msg[3] = i_msg.message_word3;

    // ---------------------------------------------------------------
    // Half-round pipeline. Each stage holds when full and its successor
    // is blocked; empty stages fill, so bubbles collapse and a stall
    // neither drops nor duplicates a transfer.
    // ---------------------------------------------------------------
    logic [NS-1:0]    w_v;
    logic [NS:0]      w_rdy;
    siph_pkg::t_lanes w_lanes [NS];
    siph_pkg::t_msg   w_msgs  [NS];

    for (genvar g = 0; g < NS; g++) begin : g_stage
        localparam siph_pkg::t_op OP = siph_pkg::stage_op(g);
        if (g == 0) begin : g_first
            siph_stage u_stage (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_op    (OP),
                .i_valid (i_msg.valid),
                .i_lanes (w_init),
                .i_msg   (w_in_msg),
                .i_ready (w_rdy[g+1]),
                .o_ready (w_rdy[g]),
                .o_valid (w_v[g]),
                .o_lanes (w_lanes[g]),
                .o_msg   (w_msgs[g])
            );
        end else begin : g_rest
            siph_stage u_stage (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_op    (OP),
                .i_valid (w_v[g-1]),
                .i_lanes (w_lanes[g-1]),
                .i_msg   (w_msgs[g-1]),
                .i_ready (w_rdy[g+1]),
                .o_ready (w_rdy[g]),
                .o_valid (w_v[g]),
                .o_lanes (w_lanes[g]),
                .o_msg   (w_msgs[g])
            );
        end
    end

    assign i_msg.ready = w_rdy[0];

    // ---------------------------------------------------------------
    // Output register: lane fold and 48-bit truncation.
    // ---------------------------------------------------------------
    logic        r_out_v;
    logic [47:0] r_out_id;
    logic [63:0] w_fold;

    assign w_rdy[NS] = !r_out_v || o_id.ready;
    assign w_fold    = w_lanes[NS-1].a ^ w_lanes[NS-1].b
                     ^ w_lanes[NS-1].c ^ w_lanes[NS-1].d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_rdy[NS]) begin
            r_out_v <= w_v[NS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[NS] && w_v[NS-1]) begin
            r_out_id <= w_fold[47:0];
        end
    end

    assign o_id.valid    = r_out_v;
    assign o_id.short_id = r_out_id;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    // Input only backs up when every stage and the output hold data.
    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_msg.ready |-> ((&w_v) && r_out_v))
        else $error("input blocked with a hole in the pipeline");

    // A ready sink lets the whole chain flow.
    a_ready_flows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_id.ready |-> i_msg.ready)
        else $error("input blocked while output is ready");

    // Output valid appears only after the last stage held data.
    a_out_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_v) |-> $past(w_v[NS-1]))
        else $error("output valid without a finished item");

endmodule

// ----- verif/siphash24_short_id_test.sv -----
module siphash24_short_id_test;

    // SipHash initialization vector, length block, finalization constant and an all-ones word
    localparam logic [63:0] IV_A      = 64'h736f_6d65_7073_6575;
    localparam logic [63:0] IV_B      = 64'h646f_7261_6e64_6f6d;
    localparam logic [63:0] IV_C      = 64'h6c79_6765_6e65_7261;
    localparam logic [63:0] IV_D      = 64'h7465_6462_7974_6573;
    localparam logic [63:0] MSG_LEN32 = 64'd32 << 56;
    localparam logic [63:0] FIN_MARK  = 64'h0000_0000_0000_00ff;
    localparam logic [63:0] ALL_ONES  = 64'hffff_ffff_ffff_ffff;

    typedef struct packed {
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [63:0] d;
    } t_sip_lanes;

    // Scoreboard: hashes each accepted digest with the current keys and
    // holds the short ids still owed by the block, oldest first.
    class t_short_id_board;
        logic [63:0] key0;
        logic [63:0] key1;
        logic [47:0] ids_due[$];
        int unsigned miscount;

        function new();
            key0     = '0;
            key1     = '0;
            miscount = 0;
        endfunction

        function logic [63:0] spin(logic [63:0] x, int unsigned r);
            return (x << r) | (x >> (64 - r));
        endfunction

        function t_sip_lanes sip_round(t_sip_lanes s);
            s.a = s.a + s.b;
            s.b = spin(s.b, 13) ^ s.a;
            s.a = spin(s.a, 32);
            s.c = s.c + s.d;
            s.d = spin(s.d, 16) ^ s.c;
            s.a = s.a + s.d;
            s.d = spin(s.d, 21) ^ s.a;
            s.c = s.c + s.b;
            s.b = spin(s.b, 17) ^ s.c;
            s.c = spin(s.c, 32);
            return s;
        endfunction

        function t_sip_lanes mix_word(t_sip_lanes s, logic [63:0] m);
            s.d = s.d ^ m;
            s = sip_round(s);
            s = sip_round(s);
            s.a = s.a ^ m;
            return s;
        endfunction

        function logic [47:0] short_id_of(siph_pkg::t_msg m);
            t_sip_lanes  s;
            logic [63:0] h;
            s.a = IV_A ^ key0;
            s.b = IV_B ^ key1;
            s.c = IV_C ^ key0;
            s.d = IV_D ^ key1;
            for (int i = 0; i < 4; i++) s = mix_word(s, m[i]);
            s = mix_word(s, MSG_LEN32);
            s.c = s.c ^ FIN_MARK;
            for (int i = 0; i < 4; i++) s = sip_round(s);
            h = s.a ^ s.b ^ s.c ^ s.d;
            return h[47:0];
        endfunction

        function void set_key(logic sel, logic [63:0] val);
            if (sel == siph_pkg::REG_KEY0) key0 = val;
            else key1 = val;
        endfunction

        function void note_digest(siph_pkg::t_msg m);
            ids_due.push_back(short_id_of(m));
        endfunction

        function void compare(string tag, logic [63:0] exp, logic [63:0] act);
            if (exp !== act) begin
                miscount++;
                if (miscount <= 10)
                    $display("%s mismatch: expected %016h, got %016h", tag, exp, act);
            end
        endfunction

        function void check_id(logic [47:0] id);
            if (ids_due.size() == 0) begin
                miscount++;
                if (miscount <= 10)
                    $display("unexpected short id %012h with nothing due", id);
            end else begin
                compare("short id", {16'h0, ids_due.pop_front()}, {16'h0, id});
            end
        endfunction

        function int unsigned pending();
            return ids_due.size();
        endfunction
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [siph_pkg::ADDR_W-1:0]   paddr;
    logic [63:0]                   pwdata;
    logic [63:0]                   prdata;
    logic                          pready;

    siph_in_if  msg_if ();
    siph_out_if id_if ();

    siphash24_short_id DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_msg   (msg_if),
        .o_id    (id_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    t_short_id_board board = new();

    // When set, neither side idles: back-to-back transfers through the pipe.
    bit no_idle = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Hard stop well beyond the slowest legal run (~800 items, each with a
    // long source gap and a long sink stall, plus the pipe fill).
    initial begin
        #8_000_000;
        $display("siphash24_short_id regression: fail");
        $finish;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle) return 0;
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Random word, biased a little toward the all-zero and all-one corners.
    function automatic logic [63:0] rand_word();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return ALL_ONES;
        return rand64();
    endfunction

    // Sink side: ready toggles with random run/stall lengths. Every branch
    // waits on the clock edge, so ready gets one update per time step.
    initial begin
        int unsigned run;
        int unsigned stall;
        forever begin
            id_if.ready <= 1'b1;
            if (no_idle) begin
                @(posedge i_clk);
            end else begin
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
                repeat (run) @(posedge i_clk);
                stall = pick_gap() + 1;
                id_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    // Every transfer on the output side is checked against the oldest id due.
    always @(posedge i_clk) begin
        if (i_rst_n && id_if.valid && id_if.ready)
            board.check_id(id_if.short_id);
    end

    // One digest on the input channel. Returns at the edge of its transfer;
    // the board notes it right there so the drain loop never races it.
    task automatic send_digest(siph_pkg::t_msg m);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            msg_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        msg_if.valid         <= 1'b1;
        msg_if.message_word0 <= m[0];
        msg_if.message_word1 <= m[1];
        msg_if.message_word2 <= m[2];
        msg_if.message_word3 <= m[3];
        @(posedge i_clk);
        while (!msg_if.ready) @(posedge i_clk);
        board.note_digest(m);
    endtask

    task automatic send_random(int unsigned count);
        siph_pkg::t_msg m;
        for (int unsigned n = 0; n < count; n++) begin
            for (int i = 0; i < 4; i++) m[i] = rand_word();
            send_digest(m);
        end
    endtask

    // Stop feeding and wait for every owed id; each digest yields exactly
    // one id, so an empty board means the pipe is empty.
    task automatic drain();
        msg_if.valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    // APB write (setup + access), then read back the same key.
    task automatic program_key(logic sel, logic [63:0] val);
        logic [siph_pkg::ADDR_W-1:0] addr;
        addr = siph_pkg::ADDR_W'({sel, 3'b000});
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        board.set_key(sel, val);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        board.compare("key readback", val, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_keys(logic [63:0] k0, logic [63:0] k1);
        drain();
        program_key(siph_pkg::REG_KEY0, k0);
        program_key(siph_pkg::REG_KEY1, k1);
    endtask

    initial begin
        siph_pkg::t_msg m;

        // known levels on every input from time zero
        i_rst_n              <= 1'b0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        msg_if.valid         <= 1'b0;
        msg_if.message_word0 <= '0;
        msg_if.message_word1 <= '0;
        msg_if.message_word2 <= '0;
        msg_if.message_word3 <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed digests with keys left at reset (all zero): corners,
        // one full word at a time, alternating bits, single walking bits.
        m = '0;
        send_digest(m);
        m = {4{ALL_ONES}};
        send_digest(m);
        for (int i = 0; i < 4; i++) begin
            m = '0;
            m[i] = ALL_ONES;
            send_digest(m);
        end
        m = {4{64'haaaa_aaaa_aaaa_aaaa}};
        send_digest(m);
        m = {4{64'h5555_5555_5555_5555}};
        send_digest(m);
        for (int i = 0; i < 4; i++) begin
            m = '0;
            m[i] = (i % 2 == 0) ? 64'h1 : 64'h8000_0000_0000_0000;
            send_digest(m);
        end
        // byte-counting digest, typical little-endian layout
        m = {64'h1f1e_1d1c_1b1a_1918, 64'h1716_1514_1312_1110,
             64'h0f0e_0d0c_0b0a_0908, 64'h0706_0504_0302_0100};
        send_digest(m);

        // keys at their upper extreme
        set_keys(ALL_ONES, ALL_ONES);
        m = '0;
        send_digest(m);
        m = {4{ALL_ONES}};
        send_digest(m);
        send_random(100);

        // mixed extremes, back-to-back traffic with no idling on either side
        set_keys('0, ALL_ONES);
        no_idle = 1'b1;
        send_random(100);
        no_idle = 1'b0;

        // classic byte-counting key
        set_keys(64'h0706_0504_0302_0100, 64'h0f0e_0d0c_0b0a_0908);
        send_random(150);

        // random keys
        for (int p = 0; p < 3; p++) begin
            set_keys(rand64(), rand64());
            send_random(130);
        end

        drain();
        // wait on for longer than the pipe to catch stray ids
        repeat (60) @(posedge i_clk);

        if (board.miscount == 0) begin
            $display("siphash24_short_id regression: pass");
        end else begin
            $display("siphash24_short_id regression: fail");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/siph_pkg.sv
rtl/core/siph_in_if.sv
rtl/core/siph_out_if.sv
rtl/core/siph_stage.sv
rtl/core/siphash24_short_id.sv
verif/siphash24_short_id_test.sv
